>>> rtl/core/aimd_pkg.sv
// Shared constants and codes for the AIMD congestion window controller.
package aimd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 16;

  localparam int TIME_W     = 32;
  localparam int RTT_THR_W  = 16;
  localparam int WIN_SIZE_W = 16;

  localparam logic [RTT_THR_W-1:0] RTT_THR_RESET = 16'd60;

  localparam logic OPC_SEND = 1'b0;
  localparam logic OPC_ACK  = 1'b1;

endpackage

>>> rtl/core/aimd_window_controller.sv
// AIMD congestion window controller with an iterative reciprocal divider.
// A send word, or an ack that leaves the window alone, goes from S_EVAL to S_DONE for its result.
// An ack that grows the window goes from S_EVAL through S_DIV, where the restoring divider
// retires one quotient bit per cycle, and S_ADD to S_DONE; a held result stalls in S_DONE.
// One word is in flight at a time, so a new word is accepted only back in S_IDLE, after S_DONE.
// Synchronous active-low reset sets the window to 1.0 and the RTT threshold to 60 ms.
module aimd_window_controller
  import aimd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int INT_BITS  = INT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic                  in_rto_flag,
  input  logic [TIME_W-1:0]     in_ack_send_time,
  input  logic [TIME_W-1:0]     in_ack_arrival_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WIN_SIZE_W-1:0] out_cwnd_int,
  input  logic                  cfg_we,
  input  logic [RTT_THR_W-1:0]  cfg_wdata
);

  localparam int WIN_W = INT_BITS + FRAC_BITS;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(Q_W + 1);

  localparam logic [WIN_W-1:0]    WIN_ONE    = WIN_W'(1) << FRAC_BITS;
  localparam logic [WIN_W-1:0]    WIN_MAX    = {WIN_W{1'b1}};
  localparam logic [INT_BITS-1:0] IP_SAT     = INT_BITS'(17'h0FFFF);
  localparam logic [CNT_W-1:0]    CNT_LAST   = CNT_W'(Q_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_ADD,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [WIN_W-1:0]        window_r;
  logic [RTT_THR_W-1:0]    rtt_thr_r;
  logic                    opcode_r;
  logic                    timeout_r;
  logic [TIME_W-1:0]       send_time_r;
  logic [TIME_W-1:0]       arr_time_r;
  logic [INT_BITS-1:0]     div_d_r;
  logic [INT_BITS-1:0]     rem_r;
  logic [Q_W-1:0]          quot_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    out_valid_r;
  logic [WIN_SIZE_W-1:0]   out_size_r;

  logic [INT_BITS-1:0]     ip;
  logic [TIME_W-1:0]       rtt;
  logic                    rtt_below;
  logic [INT_BITS:0]       trial;
  logic                    trial_ge;
  logic [INT_BITS:0]       trial_diff;
  logic [WIN_W:0]          grow_sum;
  logic [WIN_W-1:0]        halved;
  logic [WIN_SIZE_W-1:0]   size_now;

  assign ip        = window_r[WIN_W-1:FRAC_BITS];
  assign rtt       = arr_time_r - send_time_r;
  assign rtt_below = rtt[TIME_W-1] || (rtt < TIME_W'(rtt_thr_r));

  assign trial      = {rem_r, (cnt_r == '0)};
  assign trial_ge   = trial >= {1'b0, div_d_r};
  assign trial_diff = trial - {1'b0, div_d_r};

  assign grow_sum = {1'b0, window_r} + (WIN_W + 1)'(quot_r);
  assign halved   = WIN_W'({ip, {(FRAC_BITS - 1){1'b0}}});
  assign size_now = (ip > IP_SAT) ? {WIN_SIZE_W{1'b1}} : WIN_SIZE_W'(ip);

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_cwnd_int    = out_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtt_thr_r <= RTT_THR_RESET;
    end else if (cfg_we) begin
      rtt_thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= WIN_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            opcode_r    <= in_opcode;
            timeout_r   <= in_rto_flag;
            send_time_r <= in_ack_send_time;
            arr_time_r  <= in_ack_arrival_time;
            state_r     <= S_EVAL;
          end
        end
        S_EVAL: begin
          div_d_r <= (ip == '0) ? INT_BITS'(1) : ip;
          rem_r   <= '0;
          quot_r  <= '0;
          cnt_r   <= '0;
          if (opcode_r == OPC_SEND) begin
            if (timeout_r) begin
              window_r <= (ip < INT_BITS'(2)) ? WIN_ONE : halved;
            end
            state_r <= S_DONE;
          end else if (rtt_below) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          rem_r  <= trial_ge ? trial_diff[INT_BITS-1:0] : trial[INT_BITS-1:0];
          quot_r <= {quot_r[Q_W-2:0], trial_ge};
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_LAST) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          window_r <= grow_sum[WIN_W] ? WIN_MAX : grow_sum[WIN_W-1:0];
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_size_r  <= size_now;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_window_at_least_one: assert property (@(posedge clk) disable iff (!rst_n)
    window_r >= WIN_ONE)
    else $error("Window fell below 1.0.");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_d_r != '0)
    else $error("Divider started with a zero divisor.");

  a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < div_d_r)
    else $error("Divider remainder is not below the divisor.");

  a_accept_starts_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EVAL && !in_ready)
    else $error("Accepted word did not start evaluation.");

  a_result_only_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("Result raised outside the finishing step.");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the AIMD congestion window controller.
module tb
  import aimd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic              opcode;
    logic              rto_flag;
    logic [TIME_W-1:0] ack_send_time;
    logic [TIME_W-1:0] ack_arrival_time;
  } aimd_event_t;

  class window_scoreboard;
    localparam int WIN_W = INT_BITS_DEF + FRAC_BITS_DEF;

    logic [WIN_W-1:0]      window_fx;
    logic [RTT_THR_W-1:0]  threshold;
    logic [WIN_SIZE_W-1:0] size_q[$];
    int unsigned errors, n_events, n_acks, n_grows, n_halvings, n_thresholds, peak;

    function new();
      window_fx = WIN_W'(1) << FRAC_BITS_DEF;
      threshold = RTT_THR_RESET;
    endfunction

    function int unsigned pending();
      return size_q.size();
    endfunction

    function void set_threshold(logic [RTT_THR_W-1:0] value);
      threshold = value;
      n_thresholds++;
    endfunction

    function void note_event(aimd_event_t ev);
      logic [INT_BITS_DEF-1:0] whole;
      logic [TIME_W-1:0]       rtt;
      logic [WIN_W-1:0]        step;
      logic [WIN_W:0]          sum;
      logic [WIN_SIZE_W-1:0]   size;
      whole = window_fx[WIN_W-1:FRAC_BITS_DEF];
      n_events++;
      if (ev.opcode == OPC_SEND) begin
        if (ev.rto_flag) begin
          n_halvings++;
          if (whole < 2) begin
            window_fx = WIN_W'(1) << FRAC_BITS_DEF;
          end else begin
            window_fx = {whole, {FRAC_BITS_DEF{1'b0}}} >> 1;
          end
        end
      end else begin
        n_acks++;
        rtt = ev.ack_arrival_time - ev.ack_send_time;
        // A negative round-trip time counts as below any threshold.
        if (rtt[TIME_W-1] || rtt < TIME_W'(threshold)) begin
          n_grows++;
          step = (WIN_W'(1) << FRAC_BITS_DEF) / WIN_W'((whole == 0) ? 1 : whole);
          sum = {1'b0, window_fx} + step;
          window_fx = sum[WIN_W] ? '1 : sum[WIN_W-1:0];
        end
      end
      whole = window_fx[WIN_W-1:FRAC_BITS_DEF];
      size = (whole > {WIN_SIZE_W{1'b1}}) ? '1 : WIN_SIZE_W'(whole);
      if (size > peak) begin
        peak = size;
      end
      size_q.push_back(size);
    endfunction

    function void check_size(logic [WIN_SIZE_W-1:0] got);
      logic [WIN_SIZE_W-1:0] want;
      if (size_q.size() == 0) begin
        errors++;
        $error("cwnd_int: expected no word, got %0d", got);
      end else begin
        want = size_q.pop_front();
        if (got !== want) begin
          errors++;
          $error("cwnd_int: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = OPC_SEND;
  logic                  in_rto_flag = 1'b0;
  logic [TIME_W-1:0]     in_ack_send_time = '0;
  logic [TIME_W-1:0]     in_ack_arrival_time = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [WIN_SIZE_W-1:0] out_cwnd_int;
  logic                  cfg_we = 1'b0;
  logic [RTT_THR_W-1:0]  cfg_wdata = '0;

  window_scoreboard sb;
  int unsigned      cycles = 0;
  int unsigned      burst_left = 0;
  int unsigned      rx_hold_req = 0;
  int unsigned      rx_hold_left = 0;
  int unsigned      rx_mode_left = 0;
  int unsigned      rx_mode = 0;
  logic [7:0]       rx_pattern = 8'h01;

  aimd_window_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_rto_flag        (in_rto_flag),
    .in_ack_send_time   (in_ack_send_time),
    .in_ack_arrival_time(in_ack_arrival_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cwnd_int       (out_cwnd_int),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding.", cycles, sb.pending());
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_size(out_cwnd_int);
    end
  end

  always @(negedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(16, 96);
      rx_pattern = 8'($urandom) | 8'h01;
    end
    rx_mode_left--;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
        end
      endcase
    end
  end

  function automatic aimd_event_t mk(logic op, logic to, logic [TIME_W-1:0] ts,
                                     logic [TIME_W-1:0] ta);
    aimd_event_t ev;
    ev.opcode = op;
    ev.rto_flag = to;
    ev.ack_send_time = ts;
    ev.ack_arrival_time = ta;
    return ev;
  endfunction

  function automatic aimd_event_t random_event(int unsigned timeout_pct);
    aimd_event_t       ev;
    logic [TIME_W-1:0] thr;
    logic [TIME_W-1:0] rtt;
    thr = TIME_W'(sb.threshold);
    ev.opcode = ($urandom_range(0, 9) < 8) ? OPC_ACK : OPC_SEND;
    if (ev.opcode == OPC_ACK) begin
      ev.rto_flag = 1'($urandom_range(0, 1));
    end else begin
      ev.rto_flag = ($urandom_range(0, 99) < timeout_pct);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: rtt = (thr == 0) ? '0 : $urandom_range(0, thr - 1);
      4: rtt = thr;
      5: rtt = thr + 1;
      6: rtt = (thr == 0) ? '0 : thr - 1;
      7: rtt = 32'h8000_0000 | $urandom;
      8: rtt = $urandom;
      default: rtt = $urandom_range(0, 200000);
    endcase
    ev.ack_send_time = $urandom;
    ev.ack_arrival_time = (ev.opcode == OPC_ACK) ? ev.ack_send_time + rtt : $urandom;
    return ev;
  endfunction

  task automatic drive_word(input aimd_event_t ev);
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= ev.opcode;
    in_rto_flag <= ev.rto_flag;
    in_ack_send_time <= ev.ack_send_time;
    in_ack_arrival_time <= ev.ack_arrival_time;
    do @(posedge clk); while (!in_ready);
    sb.note_event(ev);
  endtask

  task automatic idle_sender(input int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic pace_sender(input bit gaps_on);
    if (gaps_on && burst_left == 0) begin
      idle_sender($urandom_range(1, 12));
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [RTT_THR_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_threshold(value);
  endtask

  initial begin
    logic [RTT_THR_W-1:0] thr_plan[5];
    int unsigned          timeout_pct;
    sb = new();
    thr_plan = '{16'd60, 16'd1000, 16'd0, 16'hFFFF, 16'($urandom_range(1, 65534))};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    drive_word(mk(OPC_SEND, 1'b0, '0, '0));
    drive_word(mk(OPC_SEND, 1'b1, '1, '1));
    drive_word(mk(OPC_ACK, 1'b0, '0, '0));
    drive_word(mk(OPC_ACK, 1'b1, 32'd100, 32'd159));
    drive_word(mk(OPC_ACK, 1'b0, 32'd100, 32'd160));
    drive_word(mk(OPC_ACK, 1'b0, '1, 32'd60));
    drive_word(mk(OPC_ACK, 1'b0, 32'd16, '0));
    drive_word(mk(OPC_ACK, 1'b1, '1, '0));
    drive_word(mk(OPC_ACK, 1'b0, '0, 32'h7FFF_FFFF));
    drive_word(mk(OPC_ACK, 1'b0, '0, 32'h8000_0000));
    drive_word(mk(OPC_ACK, 1'b0, 32'h8000_0000, 32'h8000_0000));
    drive_word(mk(OPC_SEND, 1'b1, '0, '0));
    drive_word(mk(OPC_SEND, 1'b0, '1, '1));
    drive_word(mk(OPC_SEND, 1'b1, '1, '0));
    write_threshold(16'd0);
    drive_word(mk(OPC_ACK, 1'b0, 32'h1234_5678, 32'h1234_5678));
    drive_word(mk(OPC_ACK, 1'b0, 32'd1, '0));
    drive_word(mk(OPC_ACK, 1'b0, '0, 32'd1));
    drive_word(mk(OPC_ACK, 1'b1, 32'hA5A5_5A5A, 32'hA5A5_5A5A));
    write_threshold(16'hFFFF);
    drive_word(mk(OPC_ACK, 1'b0, '0, 32'd65534));
    drive_word(mk(OPC_ACK, 1'b0, '0, 32'd65535));
    drive_word(mk(OPC_ACK, 1'b0, '0, 32'd65536));
    drive_word(mk(OPC_SEND, 1'b1, '0, '0));

    for (int phase = 0; phase < 5; phase++) begin
      write_threshold(thr_plan[phase]);
      timeout_pct = (phase == 3) ? 0 : 8;
      for (int k = 0; k < 130; k++) begin
        if (phase == 1 && k == 10) begin
          rx_hold_req = 400;
        end
        if (phase == 4 && k == 65) begin
          drain();
        end
        pace_sender(phase != 2);
        drive_word(random_event(timeout_pct));
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d words: %0d acks, %0d window increases, %0d timeout halvings.",
             sb.n_events, sb.n_acks, sb.n_grows, sb.n_halvings);
    $display("Went through %0d threshold settings; the largest window reached %0d.",
             sb.n_thresholds, sb.peak);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
